// File: hdl/mexp_pkg.sv
`timescale 1ns / 1ps
// Package for the modular exponentiation unit: field widths, the prime,
// Montgomery constants and the word and control structs. No dependencies.
package mexp_pkg;

	localparam int unsigned VAL_W        = 30;
	localparam int unsigned EXP_W        = 32;
	localparam int unsigned MONT_BITS    = VAL_W;
	localparam int unsigned EXP_BITS_DEF = 32;

	localparam logic [63:0] PRIME_W = 64'd1000000007;
	localparam logic [63:0] RADIX_W = 64'd1 << MONT_BITS;
	localparam logic [63:0] RMOD_W  = RADIX_W % PRIME_W;
	localparam logic [63:0] R2_W    = (RMOD_W * RMOD_W) % PRIME_W;

	// -1/P mod 2^MONT_BITS by Newton steps; each step doubles the good bits.
	function automatic logic [VAL_W-1:0] neg_inv_prime();
		logic [63:0] inv;
		inv = PRIME_W;
		for (int i = 0; i < 5; i++) begin
			inv = inv * (64'd2 - PRIME_W * inv);
		end
		return VAL_W'(64'd0 - inv);
	endfunction

	localparam logic [VAL_W-1:0] PRIME      = PRIME_W[VAL_W-1:0];
	localparam logic [VAL_W-1:0] MONT_UNITY = RMOD_W[VAL_W-1:0];
	localparam logic [VAL_W-1:0] MONT_R2    = R2_W[VAL_W-1:0];
	localparam logic [VAL_W-1:0] PLAIN_ONE  = VAL_W'(1);
	localparam logic [VAL_W-1:0] PRIME_NINV = neg_inv_prime();

	typedef struct packed {
		logic [VAL_W-1:0] base_value;
		logic [EXP_W-1:0] exponent;
	} in_word_t;

	typedef struct packed {
		logic [VAL_W-1:0] power_result;
	} out_word_t;

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
	} mm_req_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] r;
	} mm_rsp_t;

endpackage

// File: hdl/mexp_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one word of a given payload type.
// Depends on nothing; payload types come from mexp_pkg at instantiation.
interface mexp_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/mexp_montmul.sv
`timescale 1ns / 1ps
// Montgomery multiplier, R = 2^30, one shared 30x30 multiplier over three
// phases plus a final add and reduce. Depends on mexp_pkg.
module mexp_montmul (
	input  logic             clk,
	input  logic             arst_n,
	input  mexp_pkg::mm_req_t mm_req,
	output mexp_pkg::mm_rsp_t mm_rsp
);

	typedef enum logic [1:0] {
		MM_IDLE,
		MM_LOW,
		MM_FOLD,
		MM_FIN
	} mm_state_t;

	mm_state_t                     state_q;
	logic [mexp_pkg::VAL_W-1:0]    mul_x;
	logic [mexp_pkg::VAL_W-1:0]    mul_y;
	logic [2*mexp_pkg::VAL_W-1:0]  prod;
	logic [2*mexp_pkg::VAL_W-1:0]  t_q;
	logic [2*mexp_pkg::VAL_W-1:0]  m_q;
	logic [mexp_pkg::VAL_W-1:0]    u_q;
	logic [2*mexp_pkg::VAL_W:0]    sum;
	logic [mexp_pkg::VAL_W:0]      high;
	logic [mexp_pkg::VAL_W:0]      high_sub;
	logic [mexp_pkg::VAL_W-1:0]    r_q;
	logic                          done_q;

	// Operand select for the shared multiplier.
	always_comb begin
		case (state_q)
			MM_IDLE: begin
				mul_x = mm_req.a;
				mul_y = mm_req.b;
			end
			MM_LOW: begin
				mul_x = t_q[mexp_pkg::VAL_W-1:0];
				mul_y = mexp_pkg::PRIME_NINV;
			end
			MM_FOLD: begin
				mul_x = u_q;
				mul_y = mexp_pkg::PRIME;
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	assign prod     = (2*mexp_pkg::VAL_W)'(mul_x) * (2*mexp_pkg::VAL_W)'(mul_y);
	assign sum      = {1'b0, t_q} + {1'b0, m_q};
	assign high     = sum[2*mexp_pkg::VAL_W:mexp_pkg::VAL_W];
	assign high_sub = high - {1'b0, mexp_pkg::PRIME};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == MM_FIN);
			case (state_q)
				MM_IDLE: begin
					if (mm_req.start) begin
						t_q     <= prod;
						state_q <= MM_LOW;
					end
				end
				MM_LOW: begin
					u_q     <= prod[mexp_pkg::VAL_W-1:0];
					state_q <= MM_FOLD;
				end
				MM_FOLD: begin
					m_q     <= prod;
					state_q <= MM_FIN;
				end
				MM_FIN: begin
					// Sum is below 2P after the shift; one subtract brings it under P.
					if (high >= {1'b0, mexp_pkg::PRIME}) begin
						r_q <= high_sub[mexp_pkg::VAL_W-1:0];
					end else begin
						r_q <= high[mexp_pkg::VAL_W-1:0];
					end
					state_q <= MM_IDLE;
				end
				default: state_q <= MM_IDLE;
			endcase
		end
	end

	assign mm_rsp = '{done: done_q, r: r_q};

endmodule

// File: hdl/mexp_ctrl.sv
`timescale 1ns / 1ps
// Square-and-multiply sequencer: converts the base, walks the exponent from
// the top bit, converts back and holds the result word. Depends on mexp_pkg.
module mexp_ctrl #(
	parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	mexp_stream_if.sink       req,
	mexp_stream_if.source     rsp,
	output mexp_pkg::mm_req_t mm_req,
	input  mexp_pkg::mm_rsp_t mm_rsp
);

	localparam int unsigned CNT_W = $clog2(EXP_BITS + 1);

	typedef enum logic [2:0] {
		C_IDLE,
		C_CONV,
		C_SQR,
		C_MUL,
		C_OUT,
		C_WAIT
	} ctrl_state_t;

	ctrl_state_t                  state_q;
	logic [EXP_BITS-1:0]          exp_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [mexp_pkg::VAL_W-1:0]   base_m_q;
	logic [mexp_pkg::VAL_W-1:0]   hold_q;
	logic                         start_q;
	logic [mexp_pkg::VAL_W-1:0]   a_q;
	logic [mexp_pkg::VAL_W-1:0]   b_q;
	logic                         out_valid_q;
	logic [mexp_pkg::VAL_W-1:0]   out_data_q;
	logic [EXP_BITS+mexp_pkg::EXP_W-1:0] exp_ext;
	logic [mexp_pkg::VAL_W-1:0]   base_red;
	logic                         last_bit;
	logic                         out_free;
	logic                         out_load;
	logic                         mm_issue;

	assign exp_ext  = {{EXP_BITS{1'b0}}, req.data.exponent};
	assign base_red = (req.data.base_value >= mexp_pkg::PRIME) ?
		req.data.base_value - mexp_pkg::PRIME : req.data.base_value;
	assign last_bit = (cnt_q == CNT_W'(1));
	assign out_free = !out_valid_q || rsp.ready;
	assign out_load = out_free &&
		((state_q == C_WAIT) || ((state_q == C_OUT) && mm_rsp.done));
	assign mm_issue = ((state_q == C_IDLE) && req.valid) ||
		(mm_rsp.done && ((state_q == C_CONV) || (state_q == C_SQR) ||
		(state_q == C_MUL)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= mm_issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				C_IDLE: begin
					if (req.valid) begin
						exp_q   <= exp_ext[EXP_BITS-1:0];
						cnt_q   <= CNT_W'(EXP_BITS);
						a_q     <= base_red;
						b_q     <= mexp_pkg::MONT_R2;
						state_q <= C_CONV;
					end
				end
				C_CONV: begin
					if (mm_rsp.done) begin
						base_m_q <= mm_rsp.r;
						a_q      <= mexp_pkg::MONT_UNITY;
						b_q      <= mexp_pkg::MONT_UNITY;
						state_q  <= C_SQR;
					end
				end
				C_SQR: begin
					if (mm_rsp.done) begin
						a_q <= mm_rsp.r;
						if (exp_q[EXP_BITS-1]) begin
							b_q     <= base_m_q;
							state_q <= C_MUL;
						end else begin
							exp_q <= exp_q << 1;
							cnt_q <= cnt_q - CNT_W'(1);
							if (last_bit) begin
								b_q     <= mexp_pkg::PLAIN_ONE;
								state_q <= C_OUT;
							end else begin
								b_q     <= mm_rsp.r;
								state_q <= C_SQR;
							end
						end
					end
				end
				C_MUL: begin
					if (mm_rsp.done) begin
						a_q   <= mm_rsp.r;
						exp_q <= exp_q << 1;
						cnt_q <= cnt_q - CNT_W'(1);
						if (last_bit) begin
							b_q     <= mexp_pkg::PLAIN_ONE;
							state_q <= C_OUT;
						end else begin
							b_q     <= mm_rsp.r;
							state_q <= C_SQR;
						end
					end
				end
				C_OUT: begin
					if (mm_rsp.done) begin
						if (out_free) begin
							out_data_q <= mm_rsp.r;
							state_q    <= C_IDLE;
						end else begin
							hold_q  <= mm_rsp.r;
							state_q <= C_WAIT;
						end
					end
				end
				C_WAIT: begin
					if (out_free) begin
						out_data_q <= hold_q;
						state_q    <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign req.ready              = (state_q == C_IDLE);
	assign rsp.valid              = out_valid_q;
	assign rsp.data.power_result  = out_data_q;
	assign mm_req                 = '{start: start_q, a: a_q, b: b_q};

endmodule

// File: hdl/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
// Top level of the modular exponentiation unit: base^exponent mod 1000000007.
// Depends on mexp_pkg, mexp_stream_if, mexp_montmul and mexp_ctrl.
//
//  channel | dir | word type              | fields
//  --------+-----+------------------------+---------------------------------
//  req     | in  | mexp_pkg::in_word_t    | base_value[29:0], exponent[31:0]
//  rsp     | out | mexp_pkg::out_word_t   | power_result[29:0]
//
// Products: every modular product runs through the Montgomery unit as three
// passes through its one 30x30 multiplier, one add/reduce and one handoff.
// An item costs 2 + EXP_BITS + ones(exponent) such products, run one at a
// time through that single shared multiplier.
// Reset: arst_n clears the sequencer, the multiplier state and the output
// valid flag at once; no memory, so no clearing pass.
// Stalls: req.ready is high only while the sequencer is idle. A finished
// result sits in the output register, so a new word is taken while rsp is
// stalled; a second result waits in a hold register until the first leaves.
module modular_exponentiation_unit #(
	parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mexp_stream_if.sink   req,
	mexp_stream_if.source rsp
);

	mexp_pkg::mm_req_t mm_req;
	mexp_pkg::mm_rsp_t mm_rsp;

	// Sequencer: owns both channels and issues one product at a time.
	mexp_ctrl #(
		.EXP_BITS (EXP_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.mm_req (mm_req),
		.mm_rsp (mm_rsp)
	);

	// Shared Montgomery multiplier: all squarings, multiplies and domain
	// conversions go through it.
	mexp_montmul u_montmul (
		.clk    (clk),
		.arst_n (arst_n),
		.mm_req (mm_req),
		.mm_rsp (mm_rsp)
	);

	// Product completion: every start is followed by a done from the multiplier.
	a_mm_latency: assert property (@(posedge clk) disable iff (!arst_n)
		mm_req.start |-> ##4 mm_rsp.done)
		else $error("montgomery product did not finish in four cycles");

	// Every product leaves fully reduced.
	a_mm_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> (mm_rsp.r < mexp_pkg::PRIME))
		else $error("montgomery product not reduced below the prime");

	// Drop ready for the whole computation once a word is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("input ready while an item is in progress");

	// No new product is issued while one is still in flight.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mm_req.start |=> !mm_req.start)
		else $error("product started while another is running");

endmodule
